>>> rtl/window_filter_3x3_mean_median_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 mean / median window filter
// Same-cycle and next-cycle implication checks on the rising edge of clk,
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef WINDOW_FILTER_3X3_MEAN_MEDIAN_MACROS_SVH
`define WINDOW_FILTER_3X3_MEAN_MEDIAN_MACROS_SVH

// check cons in the same cycle as ante
`define WF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define WF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/wf33_pkg.sv
// ----------------------------------------------------------------------------
// wf33_pkg
// Shared constants, types and compare functions of the 3x3 window filter.
// ----------------------------------------------------------------------------
`default_nettype none

package wf33_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WU_W       = COL_W + 1;
  localparam int PIX_W      = 8;
  localparam int LW_W       = 12;
  localparam int FH_W       = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int RSUM_W     = PIX_W + 2;
  localparam int SUM_W      = PIX_W + 4;
  localparam int RECIP_W    = 13;
  localparam int DIV9_SHIFT = 16;
  localparam int PROD_W     = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'(7282);

  localparam logic [LW_W-1:0] LW_RESET = LW_W'(640);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(2);

  localparam logic MODE_MEAN   = 1'b0;
  localparam logic MODE_MEDIAN = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] pixel;
    logic             emit;
    logic             last;
  } entry_t;

  typedef struct packed {
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] md;
    logic [PIX_W-1:0] hi;
  } trip_t;

  function automatic logic [PIX_W-1:0] min2(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] max2(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic [PIX_W-1:0] min3(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                            logic [PIX_W-1:0] c);
    return min2(min2(a, b), c);
  endfunction

  function automatic logic [PIX_W-1:0] max3(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                            logic [PIX_W-1:0] c);
    return max2(max2(a, b), c);
  endfunction

  function automatic logic [PIX_W-1:0] med3(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                            logic [PIX_W-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic trip_t sort3(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                  logic [PIX_W-1:0] c);
    trip_t t;
    t.lo = min3(a, b, c);
    t.md = med3(a, b, c);
    t.hi = max3(a, b, c);
    return t;
  endfunction

endpackage

`default_nettype wire

>>> rtl/wf33_ram.sv
// ----------------------------------------------------------------------------
// wf33_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wf33_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/wf33_front.sv
// ----------------------------------------------------------------------------
// wf33_front
// Pixel intake: row and column counters, border classification and the two
// line stores. Every pixel leaves as one queue word with its column above.
// ----------------------------------------------------------------------------
`default_nettype none

module wf33_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [wf33_pkg::LW_W-1:0]    line_width,
  input  logic [wf33_pkg::FH_W-1:0]    frame_height,
  input  logic                         pixel_valid,
  output logic                         pixel_stall,
  input  logic [wf33_pkg::PIX_W-1:0]   pixel,
  input  logic [wf33_pkg::QCNT_W-1:0]  queue_count,
  output logic                         push,
  output wf33_pkg::entry_t             push_entry
);

  import wf33_pkg::*;

  logic [COL_W-1:0] column_count;
  logic [COL_W-1:0] column_count_next;
  logic [FH_W-1:0]  row_count;
  logic [FH_W-1:0]  row_count_next;

  logic [WU_W-1:0]  w_use;
  logic [FH_W-1:0]  h_use;
  logic             row_end;
  logic             frame_end;
  logic             accept;

  logic             s1_valid;
  logic [PIX_W-1:0] s1_pixel;
  logic [COL_W-1:0] s1_addr;
  logic             s1_emit;
  logic             s1_last;

  logic [PIX_W-1:0] top_rd;
  logic [PIX_W-1:0] mid_rd;

  logic [QCNT_W:0]  occupancy;

  always_comb begin
    if (32'(line_width) > MAX_WIDTH) begin
      w_use = WU_W'(MAX_WIDTH);
    end else if (line_width < LW_W'(3)) begin
      w_use = WU_W'(3);
    end else begin
      w_use = WU_W'(line_width);
    end
    if (frame_height < FH_W'(3)) begin
      h_use = FH_W'(3);
    end else begin
      h_use = frame_height;
    end
  end

  assign row_end   = {1'b0, column_count} >= (w_use - WU_W'(1));
  assign frame_end = row_end && (row_count >= (h_use - FH_W'(1)));

  assign occupancy   = {1'b0, queue_count} + (QCNT_W + 1)'(s1_valid);
  assign pixel_stall = occupancy >= (QCNT_W + 1)'(QDEPTH);
  assign accept      = pixel_valid && !pixel_stall;

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (accept) begin
      if (row_end) begin
        column_count_next = '0;
        row_count_next    = frame_end ? '0 : row_count + FH_W'(1);
      end else begin
        column_count_next = column_count + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      s1_valid     <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= pixel;
      s1_addr  <= column_count;
      s1_emit  <= (row_count >= FH_W'(2)) && (column_count >= COL_W'(2));
      s1_last  <= frame_end;
    end
  end

  wf33_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_line (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (mid_rd),
    .raddr (column_count),
    .rdata (top_rd)
  );

  wf33_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle_line (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (s1_pixel),
    .raddr (column_count),
    .rdata (mid_rd)
  );

  assign push             = s1_valid;
  assign push_entry.top   = top_rd;
  assign push_entry.mid   = mid_rd;
  assign push_entry.pixel = s1_pixel;
  assign push_entry.emit  = s1_emit;
  assign push_entry.last  = s1_last;

endmodule

`default_nettype wire

>>> rtl/wf33_fifo.sv
// ----------------------------------------------------------------------------
// wf33_fifo
// Short word queue between intake and the filter datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module wf33_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  wf33_pkg::entry_t             push_entry,
  input  logic                         pop,
  output wf33_pkg::entry_t             head,
  output logic                         head_valid,
  output logic [wf33_pkg::QCNT_W-1:0]  count
);

  import wf33_pkg::*;

  entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign head       = slots[rd_ptr];
  assign head_valid = count != '0;

endmodule

`default_nettype wire

>>> rtl/wf33_back.sv
// ----------------------------------------------------------------------------
// wf33_back
// 3x3 window and filter pipeline: row sort and row sums, column merge and
// total, then median select or divide by nine into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wf33_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        filter_mode,
  input  wf33_pkg::entry_t            head,
  input  logic                        head_valid,
  output logic                        pop,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [wf33_pkg::PIX_W-1:0]  filtered,
  output logic                        last
);

  import wf33_pkg::*;

  logic              adv;

  logic [PIX_W-1:0]  win [9];
  logic              w_valid;
  logic              w_last;

  logic              a_valid;
  logic              a_last;
  trip_t             a_row [3];
  logic [RSUM_W-1:0] a_sum [3];

  logic              b_valid;
  logic              b_last;
  logic [PIX_W-1:0]  b_lo;
  logic [PIX_W-1:0]  b_md;
  logic [PIX_W-1:0]  b_hi;
  logic [SUM_W-1:0]  b_sum;

  logic [PROD_W-1:0] prod;

  assign adv  = !result_valid || !result_stall;
  assign pop  = adv && head_valid;
  assign prod = PROD_W'(b_sum) * PROD_W'(RECIP9);

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid      <= 1'b0;
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      result_valid <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (adv) begin
      w_valid      <= pop && head.emit;
      a_valid      <= w_valid;
      b_valid      <= a_valid;
      result_valid <= b_valid;
      if (pop) begin
        for (int k = 0; k < 3; k++) begin
          win[k*3]   <= win[k*3+1];
          win[k*3+1] <= win[k*3+2];
        end
        win[2] <= head.top;
        win[5] <= head.mid;
        win[8] <= head.pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w_last <= head.last;
      a_last <= w_last;
      for (int k = 0; k < 3; k++) begin
        a_row[k] <= sort3(win[k*3], win[k*3+1], win[k*3+2]);
        a_sum[k] <= RSUM_W'(win[k*3]) + RSUM_W'(win[k*3+1]) + RSUM_W'(win[k*3+2]);
      end
      b_last <= a_last;
      b_lo   <= max3(a_row[0].lo, a_row[1].lo, a_row[2].lo);
      b_md   <= med3(a_row[0].md, a_row[1].md, a_row[2].md);
      b_hi   <= min3(a_row[0].hi, a_row[1].hi, a_row[2].hi);
      b_sum  <= SUM_W'(a_sum[0]) + SUM_W'(a_sum[1]) + SUM_W'(a_sum[2]);
      last   <= b_last;
      if (filter_mode == MODE_MEDIAN) begin
        filtered <= med3(b_lo, b_md, b_hi);
      end else begin
        filtered <= prod[DIV9_SHIFT +: PIX_W];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/window_filter_3x3_mean_median.sv
// ----------------------------------------------------------------------------
// window_filter_3x3_mean_median
// 3x3 mean or median filter over a raster-order 8-bit grayscale stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while pixel_stall is low and gives one result per
// interior pixel; border pixels give no result. A result follows its lower-right
// neighbour through the line store read, the queue, the window register, the
// row stage, the merge stage and the result register. Sustained rate is one
// pixel per clock while result_stall is low, set by the single read and single
// write port of each line store, both used once per pixel. pixel_stall rises
// only when the four-word queue would fill. Line stores need no clearing after
// reset. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "window_filter_3x3_mean_median_macros.svh"

module window_filter_3x3_mean_median (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wf33_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wf33_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             pixel_valid,
  output logic                             pixel_stall,
  input  logic [wf33_pkg::PIX_W-1:0]       pixel,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [wf33_pkg::PIX_W-1:0]       filtered,
  output logic                             last
);

  import wf33_pkg::*;

  logic              filter_mode;
  logic [LW_W-1:0]   line_width;
  logic [FH_W-1:0]   frame_height;

  logic              push;
  entry_t            push_entry;
  logic              pop;
  entry_t            head;
  logic              head_valid;
  logic [QCNT_W-1:0] queue_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= MODE_MEAN;
      line_width   <= LW_RESET;
      frame_height <= FH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FILTER_MODE:  filter_mode  <= cfg_data[0];
        CFG_LINE_WIDTH:   line_width   <= cfg_data[LW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  wf33_front u_front (
    .clk          (clk),
    .rst          (rst),
    .line_width   (line_width),
    .frame_height (frame_height),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .queue_count  (queue_count),
    .push         (push),
    .push_entry   (push_entry)
  );

  wf33_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .count      (queue_count)
  );

  wf33_back u_back (
    .clk          (clk),
    .rst          (rst),
    .filter_mode  (filter_mode),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .filtered     (filtered),
    .last         (last)
  );

  `WF_ASSERT_NOW(a_no_overflow, push && !pop, queue_count < QCNT_W'(QDEPTH),
    "queue overflow")
  `WF_ASSERT_NOW(a_no_underflow, pop, queue_count != '0, "queue underflow")
  `WF_ASSERT_NOW(a_no_idle_stall, queue_count == '0 && !push, !pixel_stall,
    "stall with empty queue")
  `WF_ASSERT_NEXT(a_accept_pushes, pixel_valid && !pixel_stall, push,
    "accepted pixel not pushed")

endmodule

`default_nettype wire

>>> test/window_filter_3x3_mean_median_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_filter_3x3_mean_median_checker
// Follows register writes and accepted pixels, keeps its own line stores and
// 3x3 window, and compares every accepted result word with the oldest due one.
// ----------------------------------------------------------------------------
module window_filter_3x3_mean_median_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [wf33_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wf33_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            pixel_valid,
  input  logic                            pixel_stall,
  input  logic [wf33_pkg::PIX_W-1:0]      pixel,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  logic [wf33_pkg::PIX_W-1:0]      filtered,
  input  logic                            last,
  output int                              mismatches,
  output int                              outstanding
);

  import wf33_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             frame_last;
  } filter_word_t;

  logic                     mode_q;
  logic [LW_W-1:0]          width_q;
  logic [FH_W-1:0]          height_q;
  logic [PIX_W-1:0]         upper_row [MAX_WIDTH];
  logic [PIX_W-1:0]         middle_row [MAX_WIDTH];
  logic [8:0][PIX_W-1:0]    win;
  logic [COL_W-1:0]         col_q;
  logic [FH_W-1:0]          row_q;
  filter_word_t             filtered_due [$];
  filter_word_t             oldest;
  int                       error_total = 0;

  function automatic logic [PIX_W-1:0] mean_of_window(input logic [8:0][PIX_W-1:0] v);
    logic [SUM_W-1:0] total;
    total = '0;
    for (int k = 0; k < 9; k++) total += SUM_W'(v[k]);
    return PIX_W'(total / 9);
  endfunction

  function automatic logic [PIX_W-1:0] median_of_window(input logic [8:0][PIX_W-1:0] v);
    int below;
    int not_above;
    logic [PIX_W-1:0] pick;
    pick = '0;
    for (int i = 0; i < 9; i++) begin
      below = 0;
      not_above = 0;
      for (int j = 0; j < 9; j++) begin
        if (v[j] < v[i]) below++;
        if (v[j] <= v[i]) not_above++;
      end
      if (below <= 4 && not_above >= 5) pick = v[i];
    end
    return pick;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_total++;
  endtask

  task automatic shift_in_pixel(input logic [PIX_W-1:0] p);
    logic [WU_W-1:0] w_eff;
    logic [FH_W-1:0] h_eff;
    logic [PIX_W-1:0] above2;
    logic [PIX_W-1:0] above1;
    logic             row_end;
    logic             frame_end;
    filter_word_t     word;
    w_eff = (width_q < 3) ? WU_W'(3) : (width_q > MAX_WIDTH) ? WU_W'(MAX_WIDTH) : WU_W'(width_q);
    h_eff = (height_q < 3) ? FH_W'(3) : height_q;
    above2 = upper_row[col_q];
    above1 = middle_row[col_q];
    row_end = WU_W'(col_q) >= w_eff - 1'b1;
    frame_end = row_end && (row_q >= h_eff - 1'b1);
    for (int k = 0; k < 3; k++) begin
      win[k*3]     = win[k*3 + 1];
      win[k*3 + 1] = win[k*3 + 2];
    end
    win[2] = above2;
    win[5] = above1;
    win[8] = p;
    upper_row[col_q]  = above1;
    middle_row[col_q] = p;
    if (row_q >= 2 && col_q >= 2) begin
      word.value      = mode_q ? median_of_window(win) : mean_of_window(win);
      word.frame_last = frame_end;
      filtered_due.push_back(word);
    end
    if (row_end) begin
      col_q = '0;
      row_q = frame_end ? '0 : row_q + 1'b1;
    end else begin
      col_q = col_q + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode_q   = MODE_MEAN;
      width_q  = LW_RESET;
      height_q = FH_RESET;
      win      = '0;
      col_q    = '0;
      row_q    = '0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      filtered_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FILTER_MODE:  mode_q   = cfg_data[0];
          CFG_LINE_WIDTH:   width_q  = cfg_data[LW_W-1:0];
          CFG_FRAME_HEIGHT: height_q = cfg_data[FH_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (filtered_due.size() == 0) begin
          report_mismatch($sformatf("result word %0d (last %0b) with nothing due",
                                    filtered, last));
        end else begin
          oldest = filtered_due.pop_front();
          if (filtered !== oldest.value)
            report_mismatch($sformatf("filtered %0d, expected %0d", filtered, oldest.value));
          if (last !== oldest.frame_last)
            report_mismatch($sformatf("last %0b, expected %0b", last, oldest.frame_last));
        end
      end
      if (pixel_valid && !pixel_stall) shift_in_pixel(pixel);
    end
    outstanding <= filtered_due.size();
    mismatches  <= error_total;
  end

endmodule

>>> test/window_filter_3x3_mean_median_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_filter_3x3_mean_median_tb
// Streams whole frames through the 3x3 mean / median filter under several
// register settings and idle patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module window_filter_3x3_mean_median_tb;
  import wf33_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int LONG_HOLD      = 300;
  localparam int PHASE_PIXELS   = 300;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  pixel_valid;
  logic                  pixel_stall;
  logic [PIX_W-1:0]      pixel;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [PIX_W-1:0]      filtered;
  logic                  last;

  int   mismatches;
  int   outstanding;
  int   send_pct = 0;
  int   recv_pct = 0;
  int   quiet_cycles = 0;
  int   hold_left = 0;
  logic hold_request = 1'b0;
  logic hold_served = 1'b0;

  window_filter_3x3_mean_median dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .filtered     (filtered),
    .last         (last)
  );

  window_filter_3x3_mean_median_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .filtered     (filtered),
    .last         (last),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_request && !hold_served) begin
      hold_served  <= 1'b1;
      hold_left    <= LONG_HOLD;
      result_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  always @(posedge clk) begin
    if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_pixel(input logic [PIX_W-1:0] value);
    while ($urandom_range(99) < send_pct) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= value;
    do @(posedge clk); while (pixel_stall);
    @(negedge clk);
  endtask

  // hold cfg_valid between back-to-back writes; caller drops it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic configure(input logic mode, input logic [LW_W-1:0] width,
                           input logic [FH_W-1:0] height);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom);
    data[0] = mode;
    write_reg(CFG_FILTER_MODE, data);
    data = CFG_DATA_W'($urandom);
    data[LW_W-1:0] = width;
    write_reg(CFG_LINE_WIDTH, data);
    write_reg(CFG_FRAME_HEIGHT, height);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    pixel_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(input int style, input logic [PIX_W-1:0] base);
    case (style)
      0:       return PIX_W'($urandom_range(255));
      1:       return $urandom_range(1) ? 8'hFF : 8'h00;
      default: begin
        if ($urandom_range(9) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
        return base ^ PIX_W'($urandom_range(7));
      end
    endcase
  endfunction

  task automatic send_frame(input int w_eff, input int h_eff);
    int style;
    logic [PIX_W-1:0] base;
    style = $urandom_range(2);
    base  = PIX_W'($urandom_range(255));
    repeat (w_eff * h_eff) push_pixel(pick_pixel(style, base));
  endtask

  task automatic run_phase(input int target);
    int sent;
    int w_reg;
    int h_reg;
    int w_eff;
    int h_eff;
    sent = 0;
    while (sent < target) begin
      w_reg = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 20);
      h_reg = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
      w_eff = (w_reg < 3) ? 3 : w_reg;
      h_eff = (h_reg < 3) ? 3 : h_reg;
      configure(1'($urandom_range(1)), LW_W'(w_reg), FH_W'(h_reg));
      repeat ($urandom_range(1, 2)) begin
        send_frame(w_eff, h_eff);
        sent += w_eff * h_eff;
      end
      settle();
    end
  endtask

  initial begin
    logic [PIX_W-1:0] spread [9];
    spread = '{8'd255, 8'd0, 8'd128, 8'd7, 8'd254, 8'd1, 8'd127, 8'd129, 8'd64};
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_FILTER_MODE;
    cfg_data     = '0;
    pixel_valid  = 1'b0;
    pixel        = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    configure(MODE_MEAN, LW_W'(3), FH_W'(3));
    repeat (9) push_pixel(8'hFF);
    settle();
    configure(MODE_MEDIAN, LW_W'(1), FH_W'(2));
    for (int i = 0; i < 9; i++) push_pixel(spread[i]);
    settle();

    send_pct = 15;
    recv_pct = 48;
    run_phase(PHASE_PIXELS);

    send_pct = 48;
    recv_pct = 15;
    run_phase(PHASE_PIXELS);

    // tall frame cut short by a height write between rows
    configure(MODE_MEAN, LW_W'(3), 16'hFFFF);
    repeat (12) push_pixel(PIX_W'($urandom_range(255)));
    settle();
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(5));
    cfg_valid <= 1'b0;
    repeat (3) push_pixel(PIX_W'($urandom_range(255)));
    settle();

    send_pct = 0;
    recv_pct = 0;
    hold_request <= 1'b1;
    configure(MODE_MEAN, LW_W'(8), FH_W'(4));
    send_frame(8, 4);
    settle();
    run_phase(PHASE_PIXELS);

    configure(MODE_MEAN, LW_W'(150), FH_W'(3));
    send_frame(150, 3);
    settle();
    configure(MODE_MEDIAN, LW_W'(100), FH_W'(3));
    send_frame(100, 3);
    settle();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
